### src/mrba_pkg.sv
// Shared types, codes and defaults of the multi-region bump allocator.
`default_nettype none

package mrba_pkg;

	// Default geometry of the region row
	localparam int unsigned DEF_REGION_BYTES = 4096;
	localparam int unsigned DEF_NUM_REGIONS  = 8;

	// Field widths of the channels
	localparam int unsigned KIND_W   = 1;
	localparam int unsigned SIZE_W   = 20;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned INDEX_W  = 3;
	localparam int unsigned OFFSET_W = 12;

	// Configuration registers
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 13;
	localparam int unsigned THRESHOLD_W  = 13;
	localparam int unsigned FAIL_W       = 8;

	localparam logic [CFG_IDX_W-1:0]   REG_LARGE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0]   REG_FAILURE_LIMIT   = 2'd1;

	localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 13'd4096;
	localparam logic [FAIL_W-1:0]      FAIL_LIMIT_RST = 8'd4;
	localparam logic [FAIL_W-1:0]      FAIL_MAX       = 8'd255;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED = 2'd0,
		ST_LARGE     = 2'd1,
		ST_OUT       = 2'd2,
		ST_RESET     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_WALK,
		FSM_WAIT
	} fsm_t;

	// Control from the sequencer to the region store
	typedef struct packed {
		logic wr_en;
		logic clear;
	} store_ctrl_t;

endpackage : mrba_pkg

`default_nettype wire

### src/mrba_region_store.sv
// Region store: bump offsets and failure counts with per-region valid bits.
`default_nettype none

module mrba_region_store #(
	parameter int unsigned NUM_REGIONS = mrba_pkg::DEF_NUM_REGIONS,
	parameter int unsigned USED_W      = 13,
	parameter int unsigned ADDR_W      = 3
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  mrba_pkg::store_ctrl_t       ctrl,
	input  wire  [ADDR_W-1:0]           wr_addr,
	input  wire  [USED_W-1:0]           wr_used,
	input  wire  [mrba_pkg::FAIL_W-1:0] wr_fail,
	input  wire  [ADDR_W-1:0]           rd_addr,
	output logic [USED_W-1:0]           rd_used,
	output logic [mrba_pkg::FAIL_W-1:0] rd_fail
);
	import mrba_pkg::*;

	localparam int unsigned ENTRY_W = USED_W + FAIL_W;

	logic [ENTRY_W-1:0]     mem_q [NUM_REGIONS];
	logic [NUM_REGIONS-1:0] valid_q;
	logic [ENTRY_W-1:0]     rd_data_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[wr_addr] <= {wr_used, wr_fail};
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// A region never written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
			if (ctrl.clear) begin
				valid_q <= '0;
			end else if (ctrl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_used = rd_valid_q ? rd_data_q[ENTRY_W-1:FAIL_W] : '0;
	assign rd_fail = rd_valid_q ? rd_data_q[FAIL_W-1:0] : '0;

endmodule : mrba_region_store

`default_nettype wire

### src/mrba_fit_unit.sv
// Fit check and failure count update for one region per cycle.
`default_nettype none

module mrba_fit_unit #(
	parameter int unsigned REGION_BYTES = mrba_pkg::DEF_REGION_BYTES,
	parameter int unsigned USED_W       = 13
) (
	input  wire  [USED_W-1:0]           used,
	input  wire  [mrba_pkg::FAIL_W-1:0] fail,
	input  wire  [mrba_pkg::SIZE_W-1:0] size,
	input  wire  [mrba_pkg::FAIL_W-1:0] limit,
	output logic                        fit,
	output logic [USED_W-1:0]           used_next,
	output logic [mrba_pkg::FAIL_W-1:0] fail_next,
	output logic                        over_limit
);
	import mrba_pkg::*;

	localparam int unsigned SUM_W = ((USED_W > SIZE_W) ? USED_W : SIZE_W) + 1;

	logic [SUM_W-1:0] sum;

	always_comb begin
		sum        = SUM_W'(used) + SUM_W'(size);
		fit        = (sum <= SUM_W'(REGION_BYTES));
		used_next  = sum[USED_W-1:0];
		fail_next  = (fail == FAIL_MAX) ? fail : fail + 1'b1;
		over_limit = (fail_next > limit);
	end

endmodule : mrba_fit_unit

`default_nettype wire

### src/multi_region_bump_allocator_unit.sv
// Top level of the multi-region bump allocator: sequencer, config and result registers.
//
// Arena allocator over NUM_REGIONS equal regions of REGION_BYTES each. A beat on
// the input channel is either an allocate request (kind 0) or a clear of all
// regions (kind 1); every beat yields exactly one result beat. A clear, or an
// allocate larger than large_threshold, passes through the wait state into the
// output register, and the input is ready again as its result is offered. Any
// other allocate walks the regions upward from the current region through one
// shared add/compare unit, one region per cycle, until a region fits or the
// last region has been visited (1 up to NUM_REGIONS regions), then passes
// through the wait state into the output register. The walk is bounded by that
// unit and the single read port of the region store. The input is not ready
// while an item is in flight, but a new beat is taken while the previous
// result still waits on the output; if the output still holds a beat when the
// next result is ready, that result waits in the sequencer and the input stays
// not ready until the output frees up. Region state powers up and clears to
// zero through the per-region valid bits: there is no clearing pass.
// Configuration writes are taken at any time and must only be issued while the
// block is idle.
`default_nettype none

module multi_region_bump_allocator_unit #(
	parameter int unsigned REGION_BYTES = mrba_pkg::DEF_REGION_BYTES,
	parameter int unsigned NUM_REGIONS  = mrba_pkg::DEF_NUM_REGIONS
) (
	input  wire                             clk,
	input  wire                             arst_n,
	// configuration write channel
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [mrba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [mrba_pkg::CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [mrba_pkg::KIND_W-1:0]     kind,
	input  wire  [mrba_pkg::SIZE_W-1:0]     request_size,
	// result channel
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [mrba_pkg::STATUS_W-1:0]   status,
	output logic [mrba_pkg::INDEX_W-1:0]    region_index,
	output logic [mrba_pkg::OFFSET_W-1:0]   region_offset
);
	import mrba_pkg::*;

	localparam int unsigned USED_W = $clog2(REGION_BYTES + 1);
	localparam int unsigned ADDR_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(NUM_REGIONS - 1);

	// configuration
	logic [THRESHOLD_W-1:0] large_threshold_q;
	logic [FAIL_W-1:0]      failure_limit_q;

	// sequencer
	fsm_t              state_q, state_d;
	logic [ADDR_W-1:0] cur_q;
	logic [ADDR_W-1:0] walk_q;
	logic [SIZE_W-1:0] size_q;

	// pending result and output register
	status_t             res_status_q;
	logic [INDEX_W-1:0]  res_index_q;
	logic [OFFSET_W-1:0] res_offset_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [INDEX_W-1:0]  out_index_q;
	logic [OFFSET_W-1:0] out_offset_q;

	// store and shared unit
	store_ctrl_t       st_ctrl;
	logic [ADDR_W-1:0] rd_addr;
	logic [USED_W-1:0] rd_used;
	logic [FAIL_W-1:0] rd_fail;
	logic              fit;
	logic [USED_W-1:0] used_next;
	logic [FAIL_W-1:0] fail_next;
	logic              over_limit;

	logic in_fire;
	logic is_clear;
	logic is_large;
	logic walk_last;
	logic load_out;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == FSM_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign is_clear  = (kind == KIND_CLEAR);
	assign is_large  = (request_size > SIZE_W'(large_threshold_q));
	assign walk_last = (walk_q == LAST);
	assign load_out  = (state_q == FSM_WAIT) && (!out_valid_q || out_ready);

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			large_threshold_q <= THRESHOLD_RST;
			failure_limit_q   <= FAIL_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LARGE_THRESHOLD: large_threshold_q <= cfg_data[THRESHOLD_W-1:0];
				REG_FAILURE_LIMIT:   failure_limit_q   <= cfg_data[FAIL_W-1:0];
				default: ;
			endcase
		end
	end

	mrba_region_store #(
		.NUM_REGIONS (NUM_REGIONS),
		.USED_W      (USED_W),
		.ADDR_W      (ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (st_ctrl),
		.wr_addr (walk_q),
		.wr_used (fit ? used_next : rd_used),
		.wr_fail (fit ? rd_fail : fail_next),
		.rd_addr (rd_addr),
		.rd_used (rd_used),
		.rd_fail (rd_fail)
	);

	mrba_fit_unit #(
		.REGION_BYTES (REGION_BYTES),
		.USED_W       (USED_W)
	) u_fit (
		.used       (rd_used),
		.fail       (rd_fail),
		.size       (size_q),
		.limit      (failure_limit_q),
		.fit        (fit),
		.used_next  (used_next),
		.fail_next  (fail_next),
		.over_limit (over_limit)
	);

	// Next state and store control. The read of the next region is issued while
	// the current one is evaluated, so the walk advances one region per cycle.
	always_comb begin
		state_d = state_q;
		st_ctrl = '0;
		rd_addr = '0;
		case (state_q)
			FSM_IDLE: begin
				rd_addr = cur_q;
				if (in_fire) begin
					if (is_clear) begin
						st_ctrl.clear = 1'b1;
						state_d       = FSM_WAIT;
					end else if (is_large) begin
						state_d = FSM_WAIT;
					end else begin
						state_d = FSM_WALK;
					end
				end
			end
			FSM_WALK: begin
				st_ctrl.wr_en = 1'b1;
				rd_addr       = walk_last ? '0 : walk_q + 1'b1;
				if (fit || walk_last) begin
					state_d = FSM_WAIT;
				end
			end
			FSM_WAIT: begin
				if (load_out) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Current region: zero on clear, advance past a region that failed too often
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (in_fire && is_clear) begin
			cur_q <= '0;
		end else if (state_q == FSM_WALK && !fit && over_limit && !walk_last) begin
			cur_q <= walk_q + 1'b1;
		end
	end

	// Walk pointer, request size and pending result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			walk_q <= cur_q;
			size_q <= request_size;
			res_index_q  <= '0;
			res_offset_q <= '0;
			res_status_q <= is_clear ? ST_RESET : ST_LARGE;
		end else if (state_q == FSM_WALK) begin
			if (fit) begin
				res_status_q <= ST_ALLOCATED;
				res_index_q  <= INDEX_W'(walk_q);
				res_offset_q <= OFFSET_W'(rd_used);
			end else if (walk_last) begin
				res_status_q <= ST_OUT;
			end else begin
				walk_q <= walk_q + 1'b1;
			end
		end
	end

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_offset_q <= res_offset_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign region_index  = out_index_q;
	assign region_offset = out_offset_q;

`ifndef SYNTHESIS
	// current region never points past the last region
	assert property (@(posedge clk) disable iff (!arst_n) cur_q <= LAST)
		else $error("current region out of range");

	// a clear beat leaves region 0 current
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_clear) |=> (cur_q == '0))
		else $error("clear did not reset current region");

	// a failed fit at the last region ends the walk as out of regions
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_WALK && !fit && walk_last) |=>
		(state_q == FSM_WAIT && res_status_q == ST_OUT))
		else $error("walk ran past the last region");

	// a fit ends the walk with an allocated result
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_WALK && fit) |=>
		(state_q == FSM_WAIT && res_status_q == ST_ALLOCATED))
		else $error("fit not reported as allocated");
`endif

endmodule : multi_region_bump_allocator_unit

`default_nettype wire
